[rtl/sqe_pkg.sv]
// ----------------------------------------------------------------------------
// sqe_pkg: shared definitions for the stack/queue engine
// Sizes, command and status codes, sequencer states and ring index helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package sqe_pkg;

    // Store geometry.
    localparam int DEPTH    = 64;
    localparam int MAX_OUT  = 64;
    localparam int DUMP_MAX = (DEPTH < MAX_OUT) ? DEPTH : MAX_OUT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;

    // Configuration port.
    localparam int PADDR_W  = 3;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_PRINT = 2'd3
    } cmd_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_OK         = 3'd0,
        STAT_BADARG     = 3'd1,
        STAT_PEEK_EMPTY = 3'd2,
        STAT_POP_EMPTY  = 3'd3,
        STAT_FULL       = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_DUMP = 1'b1
    } state_t;

    // Register index decoded from the byte address.
    localparam logic REG_QUEUE_MODE = 1'b0;

    // Next ring position, wrapping at the store depth.
    function automatic logic [ADDR_W-1:0] ring_inc(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == ADDR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + ADDR_W'(1);
        end
        return r;
    endfunction

    // Previous ring position, wrapping at zero.
    function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] a);
        logic [ADDR_W-1:0] r;
        if (a == '0)
        begin
            r = ADDR_W'(DEPTH - 1);
        end
        else
        begin
            r = a - ADDR_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/sqe_ram.sv]
// ----------------------------------------------------------------------------
// sqe_ram: generic single-clock RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/stack_queue_engine.sv]
// Result timing: push, pop and every error word appear in the cycle after the command is taken;
// a peek word and the first print-all word pass through the RAM read register and the result registers.
// Push and pop take one command per cycle; during peek and print-all the engine is busy and takes
// no new command until the last word is out; print-all streams n words (n up to 64).
// Reset (rst_n low, asynchronous) empties the store and selects stack mode;
// no clearing pass is run, and the receiver must take every word as it comes.
// ----------------------------------------------------------------------------
// stack_queue_engine: bounded LIFO/FIFO store of signed 32-bit words
// A ring buffer in one RAM with a top pointer and an element count. A small
// sequencer streams the store from top to tail for peek and print-all.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_queue_engine (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // Command channel.
    input  wire logic                             start,
    output      logic                             busy,
    input  wire logic [1:0]                       command,
    input  wire logic signed [sqe_pkg::DATA_W-1:0] push_value,
    input  wire logic                             value_ok,
    // Result channel.
    output      logic                             strobe,
    output      logic signed [sqe_pkg::DATA_W-1:0] out_value,
    output      logic                             has_value,
    output      logic [2:0]                       status,
    output      logic                             last,
    // Configuration port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [sqe_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [31:0]                      pwdata,
    output      logic [31:0]                      prdata,
    output      logic                             pready
);

    localparam int AW = sqe_pkg::ADDR_W;
    localparam int CW = sqe_pkg::CNT_W;
    localparam int DW = sqe_pkg::DATA_W;

    sqe_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   top_reg, top_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   rd_addr_reg, rd_addr_next;
    logic [CW-1:0]   remain_reg, remain_next;
    logic            queue_mode_reg;

    logic            strobe_reg, strobe_next;
    logic [DW-1:0]   value_reg, value_next;
    logic            has_reg, has_next;
    sqe_pkg::status_t status_reg, status_next;
    logic            last_reg, last_next;

    // RAM port signals.
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic            ram_re;
    logic [AW-1:0]   ram_raddr;
    logic [DW-1:0]   ram_rdata;

    logic            accept;
    sqe_pkg::cmd_t   cmd;
    logic            empty;
    logic            full;
    logic [CW:0]     tail_sum;
    logic [AW-1:0]   tail_addr;
    logic [CW-1:0]   dump_n;
    logic            cfg_write;

    // Command handshake and derived conditions.
    assign accept = start && (state_reg == sqe_pkg::ST_IDLE);
    assign busy   = (state_reg != sqe_pkg::ST_IDLE);
    assign cmd    = sqe_pkg::cmd_t'(command);
    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(sqe_pkg::DEPTH));

    // Tail slot: top plus count, wrapped once (the sum stays below twice the depth).
    assign tail_sum  = {{(CW + 1 - AW){1'b0}}, top_reg} + {1'b0, count_reg};
    assign tail_addr = (tail_sum >= (CW + 1)'(sqe_pkg::DEPTH))
                     ? AW'(tail_sum - (CW + 1)'(sqe_pkg::DEPTH))
                     : AW'(tail_sum);

    // Number of words a print-all streams.
    assign dump_n = (count_reg > CW'(sqe_pkg::DUMP_MAX)) ? CW'(sqe_pkg::DUMP_MAX) : count_reg;

    // Configuration register write and read-back.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sqe_pkg::REG_QUEUE_MODE) ? {31'b0, queue_mode_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queue_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == sqe_pkg::REG_QUEUE_MODE))
        begin
            queue_mode_reg <= pwdata[0];
        end
    end

    // Element store.
    sqe_ram #(
        .WIDTH(DW),
        .DEPTH(sqe_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sqe_pkg::ST_IDLE:
            begin
                if (accept && !empty && (cmd == sqe_pkg::CMD_PEEK || cmd == sqe_pkg::CMD_PRINT))
                begin
                    state_next = sqe_pkg::ST_DUMP;
                end
            end
            sqe_pkg::ST_DUMP:
            begin
                if (remain_reg == CW'(1))
                begin
                    state_next = sqe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sqe_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath: pointer updates, RAM accesses and the next result word.
    always_comb
    begin
        top_next     = top_reg;
        count_next   = count_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        strobe_next  = 1'b0;
        value_next   = value_reg;
        has_next     = has_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        ram_we       = 1'b0;
        ram_waddr    = top_reg;
        ram_wdata    = push_value;
        ram_re       = 1'b0;
        ram_raddr    = top_reg;

        case (state_reg)
            sqe_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    // Every command except a non-empty peek or print answers at once.
                    strobe_next = 1'b1;
                    value_next  = '0;
                    has_next    = 1'b0;
                    status_next = sqe_pkg::STAT_OK;
                    last_next   = 1'b1;
                    case (cmd)
                        sqe_pkg::CMD_PUSH:
                        begin
                            if (!value_ok)
                            begin
                                status_next = sqe_pkg::STAT_BADARG;
                            end
                            else if (full)
                            begin
                                status_next = sqe_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                                if (queue_mode_reg)
                                begin
                                    ram_waddr = tail_addr;
                                end
                                else
                                begin
                                    ram_waddr = sqe_pkg::ring_dec(top_reg);
                                    top_next  = sqe_pkg::ring_dec(top_reg);
                                end
                            end
                        end
                        sqe_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                status_next = sqe_pkg::STAT_POP_EMPTY;
                            end
                            else
                            begin
                                top_next   = sqe_pkg::ring_inc(top_reg);
                                count_next = count_reg - CW'(1);
                            end
                        end
                        sqe_pkg::CMD_PEEK:
                        begin
                            if (empty)
                            begin
                                status_next = sqe_pkg::STAT_PEEK_EMPTY;
                            end
                            else
                            begin
                                // A peek is a one-word stream from the top.
                                strobe_next  = 1'b0;
                                ram_re       = 1'b1;
                                rd_addr_next = sqe_pkg::ring_inc(top_reg);
                                remain_next  = CW'(1);
                            end
                        end
                        default:
                        begin
                            if (!empty)
                            begin
                                strobe_next  = 1'b0;
                                ram_re       = 1'b1;
                                rd_addr_next = sqe_pkg::ring_inc(top_reg);
                                remain_next  = dump_n;
                            end
                        end
                    endcase
                end
            end
            sqe_pkg::ST_DUMP:
            begin
                // The word read last cycle goes out; the next read is issued if any remain.
                strobe_next = 1'b1;
                value_next  = ram_rdata;
                has_next    = 1'b1;
                status_next = sqe_pkg::STAT_OK;
                last_next   = (remain_reg == CW'(1));
                if (remain_reg != CW'(1))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_addr_reg;
                    rd_addr_next = sqe_pkg::ring_inc(rd_addr_reg);
                    remain_next  = remain_reg - CW'(1);
                end
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= sqe_pkg::ST_IDLE;
            top_reg     <= '0;
            count_reg   <= '0;
            rd_addr_reg <= '0;
            remain_reg  <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            count_reg   <= count_next;
            rd_addr_reg <= rd_addr_next;
            remain_reg  <= remain_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        has_reg    <= has_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign strobe    = strobe_reg;
    assign out_value = value_reg;
    assign has_value = has_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/sqe_checker.sv]
// ----------------------------------------------------------------------------
// sqe_checker: port-level checks for the stack/queue engine
// Watches the command and result ports and flags sequencing errors.
// ----------------------------------------------------------------------------
`default_nettype none

module sqe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] command,
    input wire logic       strobe,
    input wire logic       has_value,
    input wire logic [2:0] status,
    input wire logic       last
);

    // Push and pop always answer with a single word in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command == sqe_pkg::CMD_PUSH || command == sqe_pkg::CMD_POP))
        |=> (strobe && last && !has_value))
        else $error("push/pop did not answer with one word in the next cycle");

    // A word that carries an element always reports success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && has_value) |-> (status == sqe_pkg::STAT_OK))
        else $error("element word with a failing status");

    // A stream has no gaps: a word that is not last is followed by another.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a print-all stream");

    // Only print-all streams several words, and each of them carries an element.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> (has_value && busy))
        else $error("non-final word without an element");

endmodule

bind stack_queue_engine sqe_checker u_sqe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .strobe    (strobe),
    .has_value (has_value),
    .status    (status),
    .last      (last)
);

`default_nettype wire
